[sv/alr_pkg.sv]
package alr_pkg;

	// default sizing
	localparam int ALR_CAPACITY   = 128;
	localparam int ALR_ITEM_WIDTH = 32;

	// fixed field widths
	localparam int FUNC_W     = 3;
	localparam int ITEM_W     = 32;
	localparam int POS_W      = 8;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 8;
	localparam int LIMIT_W    = 8;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 48;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;

	// request codes (6 and 7 are ignored)
	typedef enum logic [FUNC_W-1:0] {
		FN_INS_FRONT = 3'd0,
		FN_INS_BACK  = 3'd1,
		FN_INS_POS   = 3'd2,
		FN_REM_FRONT = 3'd3,
		FN_REM_BACK  = 3'd4,
		FN_REM_POS   = 3'd5
	} alr_func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} alr_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} alr_state_t;

endpackage

[sv/alr_ram.sv]
module alr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/array_list_insert_remove.sv]
// Fixed-capacity list of item words held in one synchronous RAM. Each input
// transaction inserts at the front, the back or a position, or removes from the
// front, the back or a position, and yields exactly one result transaction with
// the removed item (zero unless a removal succeeded), a status (0 ok, 1 full,
// 2 empty, 3 position out of range) and the new entry count. A failed request
// leaves the list unchanged. Entries behind the affected position are moved one
// place through the RAM, one entry per cycle (read, then written back in the
// following cycle). A request moves the entries at or behind its position
// (count - position of them); an insert at the back moves nothing. Errors and
// ignored codes move nothing. A request that finishes while an earlier result
// is still held on the output waits until that result is taken. One request is
// in work at a time; the next one is taken while the previous result still
// waits on the output.
// capacity_limit (cfg_wdata) caps the count at min(limit, CAPACITY).
module array_list_insert_remove #(
	parameter int CAPACITY   = alr_pkg::ALR_CAPACITY,
	parameter int ITEM_WIDTH = alr_pkg::ALR_ITEM_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// capacity_limit register
	input  logic                           cfg_wen,
	input  logic [alr_pkg::LIMIT_W-1:0]    cfg_wdata,
	// request: [2:0] func, [34:3] item_value, [42:35] position, zero fill
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [alr_pkg::S_TDATA_W-1:0]  s_tdata,
	// result: [31:0] removed_item, [33:32] status, [41:34] entry_count, zero fill
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [alr_pkg::M_TDATA_W-1:0]  m_tdata
);

	import alr_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	alr_state_t            state_q, state_d;
	logic [LIMIT_W-1:0]    limit_q;
	logic [CW-1:0]         count_q;

	// request fields
	logic [FUNC_W-1:0]     in_func;
	logic [ITEM_W-1:0]     in_item;
	logic [POS_W-1:0]      in_pos;

	// decode
	logic [PW-1:0]         cnt_x, pos_x, lim_x, at_x;
	logic                  is_ins, is_rem, full, empty, go;
	alr_status_t           st_d;

	// operation registers
	logic                  ins_q, first_q;
	logic [AW-1:0]         at_q, rd_ptr_q;
	logic [CW-1:0]         rd_left_q;
	logic [ITEM_WIDTH-1:0] item_q, taken_q;
	alr_status_t           st_q;

	// read pipeline
	logic                  v_s1, wr_s1, tk_s1;
	logic [AW-1:0]         wa_s1;

	// control
	logic                  accept, rd_en, run_end, load_out;

	// ram ports
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [ITEM_WIDTH-1:0] ram_wdata, ram_rdata;

	// output register
	logic                  m_valid_q;
	logic [M_TDATA_W-1:0]  m_data_q;

	assign in_func = s_tdata[2:0];
	assign in_item = s_tdata[34:3];
	assign in_pos  = s_tdata[42:35];

	// bounds checks against the current count
	always_comb begin
		cnt_x  = PW'(count_q);
		pos_x  = PW'(in_pos);
		lim_x  = (PW'(limit_q) < PW'(CAPACITY)) ? PW'(limit_q) : PW'(CAPACITY);
		full   = (cnt_x >= lim_x);
		empty  = (count_q == '0);
		is_ins = 1'b0;
		is_rem = 1'b0;
		at_x   = '0;
		st_d   = ST_OK;
		case (in_func)
			FN_INS_FRONT: begin
				is_ins = 1'b1;
				st_d   = full ? ST_FULL : ST_OK;
			end
			FN_INS_BACK: begin
				is_ins = 1'b1;
				at_x   = cnt_x;
				st_d   = full ? ST_FULL : ST_OK;
			end
			FN_INS_POS: begin
				is_ins = 1'b1;
				at_x   = pos_x;
				st_d   = full ? ST_FULL : ((pos_x > cnt_x) ? ST_RANGE : ST_OK);
			end
			FN_REM_FRONT: begin
				is_rem = 1'b1;
				st_d   = empty ? ST_EMPTY : ST_OK;
			end
			FN_REM_BACK: begin
				is_rem = 1'b1;
				at_x   = cnt_x - PW'(1);
				st_d   = empty ? ST_EMPTY : ST_OK;
			end
			FN_REM_POS: begin
				is_rem = 1'b1;
				at_x   = pos_x;
				st_d   = empty ? ST_EMPTY : ((pos_x >= cnt_x) ? ST_RANGE : ST_OK);
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
		go = (is_ins || is_rem) && (st_d == ST_OK);
	end

	// next state and control
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		accept   = 1'b0;
		rd_en    = 1'b0;
		run_end  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					accept  = 1'b1;
					state_d = go ? S_RUN : S_DONE;
				end
			end
			S_RUN: begin
				rd_en = (rd_left_q != '0);
				if (!rd_en && !v_s1) begin
					run_end = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!m_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wen) begin
			limit_q <= cfg_wdata;
		end
	end

	// entry count, updated when the shift finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (run_end) begin
			count_q <= ins_q ? (count_q + CW'(1)) : (count_q - CW'(1));
		end
	end

	// operation setup and shift pointers
	always_ff @(posedge clk) begin
		if (accept) begin
			ins_q     <= is_ins;
			first_q   <= 1'b1;
			at_q      <= AW'(at_x);
			item_q    <= ITEM_WIDTH'(in_item);
			st_q      <= st_d;
			rd_left_q <= go ? CW'(cnt_x - at_x) : '0;
			rd_ptr_q  <= is_ins ? AW'(cnt_x - PW'(1)) : AW'(at_x);
		end else if (rd_en) begin
			first_q   <= 1'b0;
			rd_left_q <= rd_left_q - CW'(1);
			rd_ptr_q  <= ins_q ? (rd_ptr_q - AW'(1)) : (rd_ptr_q + AW'(1));
		end
	end

	// read pipeline: data read at one address is written one place over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		wr_s1 <= ins_q || !first_q;
		tk_s1 <= !ins_q && first_q;
		wa_s1 <= ins_q ? (rd_ptr_q + AW'(1)) : (rd_ptr_q - AW'(1));
	end

	// removed item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			taken_q <= '0;
		end else if (v_s1 && tk_s1) begin
			taken_q <= ram_rdata;
		end
	end

	// write port: shifted entry, or the new item once the shift is done
	assign ram_we    = (v_s1 && wr_s1) || (run_end && ins_q);
	assign ram_waddr = v_s1 ? wa_s1 : at_q;
	assign ram_wdata = v_s1 ? ram_rdata : item_q;

	alr_ram #(
		.WIDTH (ITEM_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= {6'd0, COUNT_W'(count_q), st_q, ITEM_W'(taken_q)};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// the ram is only written while a request is being worked
	a_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_RUN))
		else $error("ram write outside of a request");

	// reads only run inside an operation and are followed by their write slot
	a_read_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (v_s1 && (state_q == S_RUN)))
		else $error("read not followed by its pipeline slot");

	// a failed request never starts a shift
	a_no_shift_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (st_d != ST_OK)) |=> (state_q == S_DONE))
		else $error("failed request entered the shift");

	// count changes only when a shift finishes
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!run_end |=> $stable(count_q))
		else $error("count changed outside of a completed request");

endmodule

[test/array_list_insert_remove_test.sv]
`timescale 1ns / 100ps

module array_list_insert_remove_test;
	import alr_pkg::*;

	localparam int CAP = ALR_CAPACITY;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam int RES_STATUS_LSB = ITEM_W;
	localparam int RES_COUNT_LSB = ITEM_W + STATUS_W;
	localparam int REQ_FILL_W = S_TDATA_W - FUNC_W - ITEM_W - POS_W;

	// request codes the block ignores
	localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

	typedef struct {
		logic [ITEM_W-1:0]  removed_item;
		alr_status_t        status;
		logic [COUNT_W-1:0] entry_count;
	} list_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [LIMIT_W-1:0]   cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // func, item_value, position, zero fill
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // removed_item, status, entry_count, zero fill

	// predicted list contents and capacity register
	logic [ITEM_W-1:0]  list_words[$];
	logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;

	// results still owed by the block, oldest first
	list_result_t pending_results[$];

	int error_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	array_list_insert_remove DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	// apply one request to the predicted list and return its result
	function automatic list_result_t apply_request(logic [FUNC_W-1:0] fn,
			logic [ITEM_W-1:0] item, logic [POS_W-1:0] pos);
		list_result_t res;
		int eff_limit;
		int n;
		int at;
		n = list_words.size();
		eff_limit = (limit_reg < CAP) ? limit_reg : CAP;
		res.removed_item = '0;
		res.status = ST_OK;
		case (fn)
			FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
				at = (fn == FN_INS_FRONT) ? 0 : (fn == FN_INS_BACK) ? n : int'(pos);
				if (n >= eff_limit)
					res.status = ST_FULL;
				else if (at > n)
					res.status = ST_RANGE;
				else
					list_words.insert(at, item);
			end
			FN_REM_FRONT, FN_REM_BACK, FN_REM_POS: begin
				at = (fn == FN_REM_FRONT) ? 0 :
					(fn == FN_REM_BACK) ? ((n == 0) ? 0 : n - 1) : int'(pos);
				if (n == 0)
					res.status = ST_EMPTY;
				else if (at >= n)
					res.status = ST_RANGE;
				else begin
					res.removed_item = list_words[at];
					list_words.delete(at);
				end
			end
			default: ;
		endcase
		res.entry_count = COUNT_W'(list_words.size());
		return res;
	endfunction

	function automatic logic [ITEM_W-1:0] rand_item();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
		if (error_count < 100)
			$display("%0t: mismatch on %s: expected %0h, got %0h", $time, field, want, got);
		error_count++;
	endtask

	// send one request transaction, with a random gap before it
	task automatic send_request(logic [FUNC_W-1:0] fn, logic [ITEM_W-1:0] item,
			logic [POS_W-1:0] pos);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{REQ_FILL_W{1'b0}}, pos, item, fn};
		pending_results.push_back(apply_request(fn, item, pos));
		do @(posedge clk); while (!s_tready);
	endtask

	// hold off requests until every result is back and the block is quiet
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_limit(logic [LIMIT_W-1:0] value);
		wait_idle();
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		limit_reg = value;
	endtask

	// random request; insert_pct steers the list toward full or empty
	task automatic random_request(int insert_pct);
		logic [FUNC_W-1:0] fn;
		logic [POS_W-1:0] pos;
		bit ins;
		int n;
		n = list_words.size();
		ins = ($urandom_range(99) < insert_pct);
		if ($urandom_range(99) < 3)
			fn = $urandom_range(1) ? FN_SPARE_LO : FN_SPARE_HI;
		else begin
			case ($urandom_range(2))
				0: fn = ins ? FN_INS_FRONT : FN_REM_FRONT;
				1: fn = ins ? FN_INS_BACK : FN_REM_BACK;
				default: fn = ins ? FN_INS_POS : FN_REM_POS;
			endcase
		end
		if ($urandom_range(9) == 0)
			pos = POS_W'($urandom_range(POS_MAX));
		else if (fn == FN_REM_POS && n > 0)
			pos = POS_W'($urandom_range(n - 1));
		else
			pos = POS_W'($urandom_range(n));
		send_request(fn, rand_item(), pos);
	endtask

	// empty list errors, every operation, field extremes, ignored codes
	task automatic test_basic_ops();
		send_request(FN_REM_FRONT, rand_item(), '0);
		send_request(FN_REM_BACK, rand_item(), '0);
		send_request(FN_REM_POS, rand_item(), POS_MAX);
		send_request(FN_INS_POS, rand_item(), 8'd1);
		send_request(FN_INS_FRONT, '1, '0);
		send_request(FN_INS_BACK, '0, POS_MAX);
		send_request(FN_INS_POS, 32'hA5A5_A5A5, 8'd1);
		send_request(FN_INS_POS, 32'h5A5A_5A5A, 8'd3);
		send_request(FN_INS_POS, rand_item(), POS_MAX);
		send_request(FN_SPARE_LO, '1, POS_MAX);
		send_request(FN_SPARE_HI, rand_item(), POS_W'($urandom_range(POS_MAX)));
		send_request(FN_REM_POS, rand_item(), 8'd4);
		send_request(FN_REM_POS, '1, POS_MAX);
		send_request(FN_REM_POS, rand_item(), 8'd1);
		send_request(FN_REM_BACK, rand_item(), '0);
	endtask

	// limit below count, limit of zero, limit above capacity
	task automatic test_limit_cases();
		set_limit(8'd1);
		send_request(FN_INS_BACK, rand_item(), '0);
		send_request(FN_INS_POS, rand_item(), POS_MAX);
		send_request(FN_REM_FRONT, rand_item(), '0);
		set_limit(8'd0);
		send_request(FN_INS_FRONT, rand_item(), '0);
		send_request(FN_REM_BACK, rand_item(), '0);
		set_limit(8'd255);
		send_request(FN_INS_FRONT, rand_item(), '0);
		send_request(FN_REM_POS, rand_item(), '0);
	endtask

	// fill up to the limit, overrun it, then empty and underrun
	task automatic test_fill_and_drain();
		int eff_limit;
		eff_limit = (limit_reg < CAP) ? limit_reg : CAP;
		while (list_words.size() < eff_limit)
			random_request(100);
		repeat (3) random_request(100);
		while (list_words.size() > 0)
			random_request(0);
		repeat (3) random_request(0);
	endtask

	// random mix with the insert share picked anew every 50 requests
	task automatic test_random_mix(int n_items);
		int insert_pct;
		insert_pct = 50;
		for (int i = 0; i < n_items; i++) begin
			if (i % 50 == 0) begin
				case ($urandom_range(2))
					0: insert_pct = 20;
					1: insert_pct = 50;
					default: insert_pct = 80;
				endcase
			end
			if ($urandom_range(199) == 0)
				wait_idle();
			random_request(insert_pct);
		end
	endtask

	// receiver stalls
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0)
				report_mismatch("unexpected result", '0, 64'(m_tdata));
			else begin
				want = pending_results.pop_front();
				if (m_tdata[ITEM_W-1:0] !== want.removed_item)
					report_mismatch("removed_item", 64'(want.removed_item),
						64'(m_tdata[ITEM_W-1:0]));
				if (m_tdata[RES_STATUS_LSB +: STATUS_W] !== want.status)
					report_mismatch("status", 64'(want.status),
						64'(m_tdata[RES_STATUS_LSB +: STATUS_W]));
				if (m_tdata[RES_COUNT_LSB +: COUNT_W] !== want.entry_count)
					report_mismatch("entry_count", 64'(want.entry_count),
						64'(m_tdata[RES_COUNT_LSB +: COUNT_W]));
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles lightly, receiver heavily
		send_idle_pct = 7;
		recv_idle_pct = 54;
		test_basic_ops();
		test_limit_cases();
		set_limit(8'd128);
		test_fill_and_drain();
		test_random_mix(400);

		// sender idles heavily, receiver lightly
		send_idle_pct = 54;
		recv_idle_pct = 7;
		set_limit(8'd255);
		test_fill_and_drain();
		set_limit(LIMIT_W'($urandom_range(3, 127)));
		test_fill_and_drain();
		test_random_mix(400);

		// no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_limit(8'd2);
		test_fill_and_drain();
		set_limit(8'd128);
		test_random_mix(400);
		set_limit(LIMIT_W'($urandom_range(1, 40)));
		test_random_mix(300);

		wait_idle();
		repeat (CAP + 8) @(posedge clk);
		if (error_count == 0)
			$display("array_list_insert_remove_test passed");
		else
			$display("array_list_insert_remove_test failed");
		$finish;
	end

	// watchdog
	initial begin
		#50_000_000;
		$display("array_list_insert_remove_test failed");
		$finish;
	end

endmodule

[array_list_insert_remove.f]
sv/alr_pkg.sv
sv/alr_ram.sv
sv/array_list_insert_remove.sv
test/array_list_insert_remove_test.sv
